// File: rtl/upd_pkg.sv
package upd_pkg;

    // Characters that the decoder treats specially
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] LOWER_BASE   = 8'h61 - 8'd10;
    localparam logic [7:0] UPPER_BASE   = 8'h41 - 8'd10;

    // Most results one input beat can produce
    localparam int MAX_RESULTS = 2;

    // Entries in the result queue at the output
    localparam int QDEPTH = 3;

    // One raw byte of the encoded string
    typedef struct packed {
        logic [7:0] raw_byte;
        logic       end_of_string;
    } enc_beat_t;

    // One decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_output;
    } dec_beat_t;

    // Results produced by one input beat
    typedef struct packed {
        logic [1:0] count;
        dec_beat_t  second;
        dec_beat_t  first;
    } dec_group_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [7:0] diff;
        diff = 8'd0;
        if (c inside {[8'h30:8'h39]})
            diff = c - CHAR_ZERO;
        else if (c inside {[8'h61:8'h66]})
            diff = c - LOWER_BASE;
        else if (c inside {[8'h41:8'h46]})
            diff = c - UPPER_BASE;
        return diff[3:0];
    endfunction

endpackage

// File: rtl/upd_decode.sv
module upd_decode
    import upd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  enc_beat_t  beat,
    output dec_group_t results
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    dec_beat_t  res [MAX_RESULTS];
    logic [1:0] n;
    logic [7:0] b;
    logic       b_hex;
    logic       b_pct;
    logic [7:0] b_fresh;

    // Per-byte decode: escape tracking, plus mapping, end-of-string flush
    always_comb
    begin
        b       = beat.raw_byte;
        b_hex   = is_hex(b);
        b_pct   = (b == CHAR_PERCENT);
        b_fresh = (b == CHAR_PLUS) ? CHAR_SPACE : b;

        phase_next = phase_reg;
        held_next  = held_reg;
        n          = 2'd0;
        res[0]     = '0;
        res[1]     = '0;

        case (phase_reg)
            PH_PCT:
            begin
                if (b_hex)
                begin
                    held_next  = b;
                    phase_next = PH_DIGIT;
                end
                else if (b_pct)
                    phase_next = PH_PCT;
                else
                begin
                    phase_next = PH_IDLE;
                    res[n[0]]  = '{out_byte: b_fresh, byte_valid: 1'b1, end_of_output: 1'b0};
                    n          = n + 2'd1;
                end
            end
            PH_DIGIT:
            begin
                if (b_hex)
                begin
                    res[n[0]]  = '{out_byte: {hex_value(held_reg), hex_value(b)},
                                   byte_valid: 1'b1, end_of_output: 1'b0};
                    n          = n + 2'd1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    // bad second digit: held digit goes out as is
                    res[n[0]] = '{out_byte: held_reg, byte_valid: 1'b1, end_of_output: 1'b0};
                    n         = n + 2'd1;
                    if (b_pct)
                        phase_next = PH_PCT;
                    else
                    begin
                        phase_next = PH_IDLE;
                        res[n[0]]  = '{out_byte: b_fresh, byte_valid: 1'b1,
                                       end_of_output: 1'b0};
                        n          = n + 2'd1;
                    end
                end
            end
            default:
            begin
                if (b_pct)
                    phase_next = PH_PCT;
                else
                begin
                    phase_next = PH_IDLE;
                    res[n[0]]  = '{out_byte: b_fresh, byte_valid: 1'b1, end_of_output: 1'b0};
                    n          = n + 2'd1;
                end
            end
        endcase

        // end of string: flush a held digit, mark the last result
        if (beat.end_of_string)
        begin
            if (phase_next == PH_DIGIT)
            begin
                res[n[0]] = '{out_byte: held_next, byte_valid: 1'b1, end_of_output: 1'b0};
                n         = n + 2'd1;
            end
            if (n == 2'd0)
            begin
                res[0] = '0;
                n      = 2'd1;
            end
            res[n[0] ^ 1'b1].end_of_output = 1'b1;
            phase_next = PH_IDLE;
            held_next  = 8'd0;
        end

        results.count  = n;
        results.first  = res[0];
        results.second = res[1];
    end

    // Escape state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

// File: rtl/url_percent_decoder.sv
// URL percent decoder.
// enc channel: one raw byte per beat with an end_of_string flag.
// dec channel: decoded bytes, one per beat; end_of_output marks the last
// result of a string, and a string that decodes to nothing gives one beat
// with byte_valid low.
// Both channels use valid/stall: a beat moves on an edge with valid high
// and stall low.
// A result reaches dec only from the registered result queue.
// Throughput: one input beat per cycle while enc_stall is low. A beat
// that yields two results (a broken escape) puts both in the three-entry
// result queue, and enc_stall rises once two results are waiting;
// enc_stall is decoded from the registered queue count.
// When the receiver stalls dec, the head result holds and the queue keeps
// taking input until two results are queued.
// Reset clears the escape state and empties the queue; no beat is offered
// on dec until a new input is taken.
module url_percent_decoder
    import upd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      enc_valid,
    output logic      enc_stall,
    input  enc_beat_t enc_beat,
    output logic      dec_valid,
    input  logic      dec_stall,
    output dec_beat_t dec_beat
);

    dec_group_t results;
    logic       take;
    logic       pop;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] cnt_kept;
    logic [1:0] push_n;
    dec_beat_t  q_reg  [QDEPTH];
    dec_beat_t  q_next [QDEPTH];

    assign enc_stall = (cnt_reg >= 2'd2);
    assign take      = enc_valid && !enc_stall;
    assign dec_valid = (cnt_reg != 2'd0);
    assign dec_beat  = q_reg[0];
    assign pop       = dec_valid && !dec_stall;

    upd_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .beat    (enc_beat),
        .results (results)
    );

    // Result queue: shift out at the head, append new results behind
    always_comb
    begin
        cnt_kept = cnt_reg - {1'b0, pop};
        push_n   = take ? results.count : 2'd0;
        for (int i = 0; i < QDEPTH; i++)
        begin
            if (pop && (i < QDEPTH - 1))
                q_next[i] = q_reg[i + 1];
            else
                q_next[i] = q_reg[i];
            if ((push_n != 2'd0) && (2'(i) == cnt_kept))
                q_next[i] = results.first;
            if ((push_n == 2'd2) && (2'(i) == 2'(cnt_kept + 2'd1)))
                q_next[i] = results.second;
        end
        cnt_next = cnt_kept + push_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
            q_reg[i] <= q_next[i];
    end

endmodule
